// ----- design/zobrist_state_hash_top_macros.svh -----
// assertion macros shared by the zobrist state hash modules
`ifndef ZOBRIST_STATE_HASH_TOP_MACROS_SVH
`define ZOBRIST_STATE_HASH_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define ZSH_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("zsh assertion failed");

// next-cycle implication, checked out of reset
`define ZSH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("zsh assertion failed");

`else

`define ZSH_ASSERT_IMPL(label, ante, cons)

`define ZSH_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- design/zsh_pkg.sv -----
// shared types and constants of the zobrist state hash
package zsh_pkg;

	localparam int VAR_W   = 6;
	localparam int COL_W   = 4;
	localparam int WORD_W  = 32;
	localparam int DSIZE_W = 5;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// word index of the mode register on the config port
	localparam logic REG_IDX_POLY_MODE = 1'b0;

	typedef enum logic [1:0] {
		OP_TABLE_WR  = 2'd0,
		OP_DOMAIN_WR = 2'd1,
		OP_HASH      = 2'd2
	} op_t;

	// one classified item on its way to the back end
	typedef struct packed {
		op_t                op;
		logic [VAR_W-1:0]   var_idx;
		logic [COL_W-1:0]   col;
		logic [WORD_W-1:0]  word;
		logic [DSIZE_W-1:0] dsize;
		logic               var_ok;
		logic               col_ok;
		logic               last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ----- design/zsh_front.sv -----
// front end: accepts items, range-checks them and drops the ones with no effect
module zsh_front #(
	parameter int MAX_VARIABLES = 64,
	parameter int MAX_DOMAIN    = 16
) (
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [1:0]                     operation,
	input  logic [zsh_pkg::VAR_W-1:0]      var_index,
	input  logic [zsh_pkg::COL_W-1:0]      value_index,
	input  logic [zsh_pkg::WORD_W-1:0]     table_word,
	input  logic [zsh_pkg::DSIZE_W-1:0]    domain_size,
	input  logic [zsh_pkg::COL_W-1:0]      state_value,
	input  logic                           last,
	input  zsh_pkg::q_status_t             q_status,
	input  logic                           clearing,
	output logic                           push,
	output zsh_pkg::cmd_t                  push_cmd
);
	import zsh_pkg::*;

	logic             var_ok;
	logic             col_ok;
	logic             keep;
	logic [COL_W-1:0] col_sel;

	assign col_sel = (op_t'(operation) == OP_TABLE_WR) ? value_index : state_value;
	assign var_ok  = 32'(var_index) < 32'(MAX_VARIABLES);
	assign col_ok  = 32'(col_sel) < 32'(MAX_DOMAIN);

	// out-of-range writes and unused codes leave no trace
	always_comb begin
		keep = 1'b0;
		unique case (op_t'(operation))
			OP_TABLE_WR:  keep = var_ok && col_ok;
			OP_DOMAIN_WR: keep = var_ok;
			OP_HASH:      keep = 1'b1;
			default:      keep = 1'b0;
		endcase
	end

	assign item_stall = q_status.full || clearing;
	assign push       = item_valid && !item_stall && keep;

	always_comb begin
		push_cmd.op      = op_t'(operation);
		push_cmd.var_idx = var_index;
		push_cmd.col     = col_sel;
		push_cmd.word    = table_word;
		push_cmd.dsize   = domain_size;
		push_cmd.var_ok  = var_ok;
		push_cmd.col_ok  = col_ok;
		push_cmd.last    = last;
	end

endmodule

// ----- design/zsh_queue.sv -----
// short command queue between front and back end
`include "zobrist_state_hash_top_macros.svh"

module zsh_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  zsh_pkg::cmd_t      push_cmd,
	input  logic               pop,
	output zsh_pkg::cmd_t      head,
	output zsh_pkg::q_status_t status
);
	import zsh_pkg::*;

	cmd_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign head         = slots_q[rd_ptr_q];
	assign status.full  = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign status.empty = cnt_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	`ZSH_ASSERT_IMPL(a_no_push_full, push, !status.full)
	`ZSH_ASSERT_IMPL(a_no_pop_empty, pop, !status.empty)
	`ZSH_ASSERT_NEXT(a_fill_count, push && !pop, cnt_q == $past(cnt_q) + QCNT_W'(1))

endmodule

// ----- design/zsh_back.sv -----
// back end: table and domain memories, clearing pass, hash combine and result register
`include "zobrist_state_hash_top_macros.svh"

module zsh_back #(
	parameter int MAX_VARIABLES = 64,
	parameter int MAX_DOMAIN    = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           polynomial_mode,
	input  zsh_pkg::q_status_t             q_status,
	input  zsh_pkg::cmd_t                  head,
	output logic                           pop,
	output logic                           clearing,
	output logic                           hash_valid,
	input  logic                           hash_stall,
	output logic [zsh_pkg::WORD_W-1:0]     hash_value
);
	import zsh_pkg::*;

	localparam int DEPTH = MAX_VARIABLES * MAX_DOMAIN;
	localparam int AW    = $clog2(DEPTH);
	localparam int VW    = (MAX_VARIABLES > 1) ? $clog2(MAX_VARIABLES) : 1;
	localparam int CW    = $clog2(MAX_DOMAIN);

	logic [WORD_W-1:0]  table_mem [DEPTH];
	logic [DSIZE_W-1:0] dom_mem   [MAX_VARIABLES];

	// clearing sweep
	logic          clr_active_q;
	logic [AW-1:0] clr_addr_q;
	logic [VW-1:0] clr_row_q;
	logic [CW-1:0] clr_col_q;
	logic          clr_last;

	// issue side
	logic               adv;
	logic [AW-1:0]      row_base;
	logic [AW-1:0]      rd_addr;
	logic [VW-1:0]      dom_row;
	logic               tbl_we;
	logic [AW-1:0]      tbl_waddr;
	logic [WORD_W-1:0]  tbl_wdata;
	logic               dom_we;
	logic [VW-1:0]      dom_waddr;
	logic [DSIZE_W-1:0] dom_wdata;

	// read stage
	logic               valid_s1;
	logic               last_s1;
	logic               word_ok_s1;
	logic               row_ok_s1;
	logic [WORD_W-1:0]  word_rd_s1;
	logic [WORD_W-1:0]  word0_rd_s1;
	logic [DSIZE_W-1:0] dsize_rd_s1;

	// combine
	logic [WORD_W-1:0]  run_hash_q;
	logic [DSIZE_W-1:0] prev_dsize_q;
	logic [WORD_W-1:0]  word;
	logic [WORD_W-1:0]  word0;
	logic [WORD_W-1:0]  prod;
	logic [WORD_W-1:0]  hash_next;
	logic [DSIZE_W-1:0] dsize_next;

	logic               hash_valid_q;
	logic [WORD_W-1:0]  hash_value_q;

	assign clearing   = clr_active_q;
	assign hash_valid = hash_valid_q;
	assign hash_value = hash_value_q;

	assign clr_last = clr_addr_q == AW'(DEPTH - 1);
	assign adv      = !(hash_valid_q && hash_stall);
	assign pop      = adv && !clr_active_q && !q_status.empty;

	assign row_base = AW'(head.var_idx) * AW'(MAX_DOMAIN);
	assign rd_addr  = row_base + AW'(head.col);
	assign dom_row  = VW'(head.var_idx);

	assign tbl_we    = clr_active_q || (pop && head.op == OP_TABLE_WR);
	assign tbl_waddr = clr_active_q ? clr_addr_q : rd_addr;
	assign tbl_wdata = clr_active_q ? '0 : head.word;

	assign dom_we    = (clr_active_q && clr_col_q == '0) || (pop && head.op == OP_DOMAIN_WR);
	assign dom_waddr = clr_active_q ? clr_row_q : dom_row;
	assign dom_wdata = clr_active_q ? DSIZE_W'(1) : head.dsize;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
			clr_row_q    <= '0;
			clr_col_q    <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_col_q == CW'(MAX_DOMAIN - 1)) begin
				clr_col_q <= '0;
				clr_row_q <= clr_row_q + VW'(1);
			end else begin
				clr_col_q <= clr_col_q + CW'(1);
			end
			if (clr_last) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			table_mem[tbl_waddr] <= tbl_wdata;
		end
		if (dom_we) begin
			dom_mem[dom_waddr] <= dom_wdata;
		end
		if (adv) begin
			word_rd_s1  <= table_mem[rd_addr];
			word0_rd_s1 <= table_mem[row_base];
			dsize_rd_s1 <= dom_mem[dom_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			last_s1    <= 1'b0;
			word_ok_s1 <= 1'b0;
			row_ok_s1  <= 1'b0;
		end else if (adv) begin
			valid_s1   <= pop && head.op == OP_HASH;
			last_s1    <= head.last;
			word_ok_s1 <= head.var_ok && head.col_ok;
			row_ok_s1  <= head.var_ok;
		end
	end

	// out-of-range lookups read as zero
	assign word  = word_ok_s1 ? word_rd_s1 : '0;
	assign word0 = row_ok_s1 ? word0_rd_s1 : '0;
	assign prod  = run_hash_q * WORD_W'(prev_dsize_q);

	always_comb begin
		hash_next  = run_hash_q;
		dsize_next = prev_dsize_q;
		if (!polynomial_mode) begin
			hash_next = run_hash_q ^ word;
		end else if (word0 != '0) begin
			hash_next  = prod + word;
			dsize_next = dsize_rd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_hash_q   <= '0;
			prev_dsize_q <= DSIZE_W'(1);
			hash_valid_q <= 1'b0;
		end else if (adv) begin
			hash_valid_q <= valid_s1 && last_s1;
			if (valid_s1) begin
				if (last_s1) begin
					run_hash_q   <= '0;
					prev_dsize_q <= DSIZE_W'(1);
				end else begin
					run_hash_q   <= hash_next;
					prev_dsize_q <= dsize_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && last_s1) begin
			hash_value_q <= hash_next;
		end
	end

	`ZSH_ASSERT_IMPL(a_clear_idle, clr_active_q, !valid_s1 && !hash_valid_q)
	`ZSH_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv, valid_s1 && $stable(last_s1))
	`ZSH_ASSERT_NEXT(a_last_emits, adv && valid_s1 && last_s1, hash_valid_q && hash_value_q == $past(hash_next))
	`ZSH_ASSERT_NEXT(a_last_restart, adv && valid_s1 && last_s1, run_hash_q == '0 && prev_dsize_q == DSIZE_W'(1))

endmodule

// ----- design/zobrist_state_hash_top.sv -----
// top level of the zobrist state hash: config register, front end, queue and back end
// a hash item passes through the queue, the table read register and the combine register before its result shows
// throughput: one item per cycle unless stalled, set by the single table write port and the multiply-add
// reset: after arst_n releases, a clearing pass over all MAX_VARIABLES*MAX_DOMAIN table words (1024 by default)
// zeroes the table and sets every domain size to one; item_stall stays high throughout
// polynomial_mode resets to xor folding; config writes are taken during the clearing pass
module zobrist_state_hash_top #(
	parameter int MAX_VARIABLES = 64,
	parameter int MAX_DOMAIN    = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// config port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [2:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	// item channel
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [1:0]                     operation,
	input  logic [zsh_pkg::VAR_W-1:0]      var_index,
	input  logic [zsh_pkg::COL_W-1:0]      value_index,
	input  logic [zsh_pkg::WORD_W-1:0]     table_word,
	input  logic [zsh_pkg::DSIZE_W-1:0]    domain_size,
	input  logic [zsh_pkg::COL_W-1:0]      state_value,
	input  logic                           last,
	// result channel
	output logic                           hash_valid,
	input  logic                           hash_stall,
	output logic [zsh_pkg::WORD_W-1:0]     hash_value
);
	import zsh_pkg::*;

	logic      poly_mode_q;
	logic      cfg_wr;
	logic      push;
	logic      pop;
	logic      clearing;
	cmd_t      push_cmd;
	cmd_t      head;
	q_status_t q_status;

	// config register, byte offset within the word is ignored
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && paddr[2] == REG_IDX_POLY_MODE;
	assign prdata = (paddr[2] == REG_IDX_POLY_MODE) ? {31'b0, poly_mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_mode_q <= 1'b0;
		end else if (cfg_wr) begin
			poly_mode_q <= pwdata[0];
		end
	end

	// front end classifies items and pushes the ones that matter
	zsh_front #(
		.MAX_VARIABLES (MAX_VARIABLES),
		.MAX_DOMAIN    (MAX_DOMAIN)
	) u_front (
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.operation   (operation),
		.var_index   (var_index),
		.value_index (value_index),
		.table_word  (table_word),
		.domain_size (domain_size),
		.state_value (state_value),
		.last        (last),
		.q_status    (q_status),
		.clearing    (clearing),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	// decouples acceptance from result back-pressure
	zsh_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	// back end does the memory work and the running hash
	zsh_back #(
		.MAX_VARIABLES (MAX_VARIABLES),
		.MAX_DOMAIN    (MAX_DOMAIN)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.polynomial_mode (poly_mode_q),
		.q_status        (q_status),
		.head            (head),
		.pop             (pop),
		.clearing        (clearing),
		.hash_valid      (hash_valid),
		.hash_stall      (hash_stall),
		.hash_value      (hash_value)
	);

endmodule
